/* hw/rtl/simple_moving_average_macros.svh */
// ----------------------------------------------------------------------------
// Moving average assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_MOVING_AVERAGE_MACROS_SVH
`define SIMPLE_MOVING_AVERAGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sma_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average package
// Field widths, reset value of the window register and the divider lane types.
// ----------------------------------------------------------------------------
package sma_pkg;

    // Price and average fields, hundredths
    localparam int PRICE_W   = 24;
    // Window length register
    localparam int WLEN_W    = 5;
    localparam int CFG_RESET = 3;
    // Divider: remainder stays below the window, one quotient bit per cell
    localparam int REM_W     = WLEN_W;
    localparam int QUO_W     = PRICE_W;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  dq;
        logic [WLEN_W-1:0] win;
    } div_data_t;

    typedef struct packed {
        logic      valid;
        div_data_t data;
    } div_lane_t;

endpackage

/* hw/rtl/sma_stream_if.sv */
// ----------------------------------------------------------------------------
// Moving average stream interfaces
// Valid/ready channels for the price samples and the averages.
// ----------------------------------------------------------------------------
interface sma_price_if;
    import sma_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface sma_avg_if;
    import sma_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

/* hw/rtl/sma_tap_cell.sv */
// ----------------------------------------------------------------------------
// Moving average sample cell
// One link of the sample line: takes its neighbour's sample on each transfer.
// ----------------------------------------------------------------------------
module sma_tap_cell (
    input  logic                        clk,
    input  logic                        shift_en,
    input  logic [sma_pkg::PRICE_W-1:0] din,
    output logic [sma_pkg::PRICE_W-1:0] dout
);
    import sma_pkg::*;

    logic [PRICE_W-1:0] sample_reg;

    // Advance the sample line by one place
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

/* hw/rtl/sma_div_cell.sv */
// ----------------------------------------------------------------------------
// Moving average divider cell
// One restoring division step: shifts in a dividend bit, settles one quotient bit.
// ----------------------------------------------------------------------------
module sma_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  sma_pkg::div_lane_t lane_in,
    output sma_pkg::div_lane_t lane_out
);
    import sma_pkg::*;

    logic            valid_reg;
    div_data_t       data_reg;
    div_data_t       data_next;
    logic [REM_W:0]  trial;
    logic [REM_W:0]  diff;
    logic            ge;

    // Trial subtract of the window from the shifted remainder
    always_comb
    begin
        trial = {lane_in.data.rem, lane_in.data.dq[QUO_W-1]};
        diff  = trial - {1'b0, lane_in.data.win};
        ge    = (trial >= {1'b0, lane_in.data.win});
        data_next.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        data_next.dq  = {lane_in.data.dq[QUO_W-2:0], ge};
        data_next.win = lane_in.data.win;
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= lane_in.valid;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign lane_out.valid = valid_reg;
    assign lane_out.data  = data_reg;

endmodule

/* hw/rtl/simple_moving_average.sv */
// ----------------------------------------------------------------------------
// Simple moving average
// Mean of the most recent window of price samples, in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one price per transfer; out_ch carries one average per
//   transfer. Samples during warm-up (fewer than the window so far) give no
//   average; every later sample gives exactly one, in order.
//   cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX) and restart the warm-up; write only idle.
//   Throughput: one sample per cycle while out_ch is not stalled. The rate
//   is set by the running-sum register, updated once per transfer from the
//   sample line tap. Path: an input transfer loads the sum register and
//   the head of the divider row together; each cell of the row then settles
//   one quotient bit, and the last cell drives out_ch.
//   Reset: window 3, sum and sample count cleared, divider row empty.
//   Stall: while an average waits on out_ch, the whole divider row holds and
//   in_ch.ready is low; bubbles from warm-up samples travel down the row.
// ----------------------------------------------------------------------------
module simple_moving_average #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [sma_pkg::WLEN_W-1:0] cfg_wr_data,
    sma_price_if.sink                  in_ch,
    sma_avg_if.source                  out_ch
);
    import sma_pkg::*;

    localparam int IDX_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W     = PRICE_W + $clog2(WINDOW_MAX);
    localparam int WLEN_MAX  = (2 ** WLEN_W) - 1;
    localparam logic [WLEN_W-1:0] WIN_CAP =
        WLEN_W'((WINDOW_MAX > WLEN_MAX) ? WLEN_MAX : WINDOW_MAX);
    localparam logic [WLEN_W-1:0] WIN_RESET =
        WLEN_W'((CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET);

    function automatic logic [WLEN_W-1:0] clamp_window(input logic [WLEN_W-1:0] v);
        logic [WLEN_W-1:0] w;
        priority if (v == '0)
        begin
            w = WLEN_W'(1);
        end
        else if (v > WIN_CAP)
        begin
            w = WIN_CAP;
        end
        else
        begin
            w = v;
        end
        return w;
    endfunction

    logic [WLEN_W-1:0]  win_reg;
    logic [WLEN_W-1:0]  win_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [WLEN_W-1:0]  seen_reg;
    logic [WLEN_W-1:0]  seen_next;
    logic               full;
    logic               emit;
    logic               advance;
    logic               accept;
    logic [PRICE_W-1:0] oldest;
    logic [PRICE_W-1:0] tap_in  [WINDOW_MAX];
    logic [PRICE_W-1:0] tap_out [WINDOW_MAX];
    logic               head_valid_reg;
    div_data_t          head_data_reg;
    div_data_t          head_data_next;
    div_lane_t          lane [QUO_W+1];

    // Handshake: the whole row moves unless an average waits
    assign advance      = !lane[QUO_W].valid || out_ch.ready;
    assign accept       = in_ch.valid && advance;
    assign in_ch.ready  = advance;
    assign out_ch.valid = lane[QUO_W].valid;
    assign out_ch.average = lane[QUO_W].data.dq;

    // Sample line: newest at the front, the displaced sample at window minus one
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_tap
            if (gi == 0)
            begin : g_first
                assign tap_in[gi] = in_ch.price;
            end
            else
            begin : g_rest
                assign tap_in[gi] = tap_out[gi-1];
            end
            sma_tap_cell u_tap (
                .clk      (clk),
                .shift_en (accept),
                .din      (tap_in[gi]),
                .dout     (tap_out[gi])
            );
        end
    endgenerate

    assign oldest = tap_out[IDX_W'(win_reg - WLEN_W'(1))];

    // Running sum and warm-up count
    always_comb
    begin
        win_next  = clamp_window(cfg_wr_data);
        full      = (seen_reg >= win_reg);
        seen_next = full ? seen_reg : seen_reg + WLEN_W'(1);
        sum_next  = sum_reg - (full ? SUM_W'(oldest) : SUM_W'(0)) + SUM_W'(in_ch.price);
        emit      = (seen_next >= win_reg);
        head_data_next.rem = REM_W'(sum_next >> PRICE_W);
        head_data_next.dq  = sum_next[PRICE_W-1:0];
        head_data_next.win = win_reg;
    end

    // Hold window, sum and count; a register write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_RESET;
            sum_reg  <= '0;
            seen_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            win_reg  <= win_next;
            sum_reg  <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            sum_reg  <= sum_next;
            seen_reg <= seen_next;
        end
    end

    // Head of the divider row: drop warm-up samples as bubbles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            head_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_data_reg <= head_data_next;
        end
    end

    assign lane[0].valid = head_valid_reg;
    assign lane[0].data  = head_data_reg;

    // Divider row: one quotient bit per cell, the last cell drives out_ch
    generate
        for (gi = 0; gi < QUO_W; gi++)
        begin : g_div
            sma_div_cell u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (lane[gi]),
                .lane_out (lane[gi+1])
            );
        end
    endgenerate

endmodule

/* hw/rtl/sma_checker.sv */
// ----------------------------------------------------------------------------
// Moving average port checker
// Handshake and flow-control checks on the top level's channels.
// ----------------------------------------------------------------------------
`include "simple_moving_average_macros.svh"

module sma_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sma_pkg::PRICE_W-1:0] out_average
);
    import sma_pkg::*;

    // A stalled average stays offered and unchanged
    `SMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_average), "stalled average changed or dropped")

    // With nothing waiting on the output, samples are always taken
    `SMA_ASSERT_SAME(a_in_open, !out_valid, in_ready, "input blocked without output stall")

    // A waiting average holds back the input
    `SMA_ASSERT_SAME(a_in_block, out_valid && !out_ready, !in_ready, "input taken during output stall")

    // An offered sample is refused only while no average leaves on out_ch
    `SMA_ASSERT_SAME(a_in_xfer, in_valid && !in_ready, !out_valid || !out_ready, "input closed without cause")

endmodule

bind simple_moving_average sma_checker u_sma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_average (out_ch.average)
);
